[src/gpg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package gpg_pkg;
    localparam int FIELD_W = 64;
    localparam int WIDTH   = 64;
    localparam int CNT_W   = $clog2(WIDTH + 1);

    typedef logic [2:0] cell_op_t;

    localparam cell_op_t OP_HOLD     = 3'd0;
    localparam cell_op_t OP_LOAD     = 3'd1;
    localparam cell_op_t OP_SH_BOTH  = 3'd2;
    localparam cell_op_t OP_SH_A     = 3'd3;
    localparam cell_op_t OP_SH_B     = 3'd4;
    localparam cell_op_t OP_RED      = 3'd5;
    localparam cell_op_t OP_RED_SWAP = 3'd6;
    localparam cell_op_t OP_SWAP     = 3'd7;

    // shift left of a shares the hold code slot through a separate flag
    typedef struct packed {
        cell_op_t op;
        logic     shl_a;
    } cell_ctrl_t;
endpackage
`default_nettype wire

[src/gpg_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface gpg_req_if import gpg_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] poly_a;
    logic [FIELD_W-1:0] poly_b;
    modport source (output valid, output poly_a, output poly_b, input ready);
    modport sink (input valid, input poly_a, input poly_b, output ready);
endinterface

interface gpg_rsp_if import gpg_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] gcd_poly;
    modport source (output valid, output gcd_poly, input ready);
    modport sink (input valid, input gcd_poly, output ready);
endinterface
`default_nettype wire

[src/gpg_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module gpg_cell
    import gpg_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       load_a,
    input  wire logic       load_b,
    input  wire logic       a_up,
    input  wire logic       b_up,
    input  wire logic       a_dn,
    output logic            a_bit,
    output logic            b_bit
);
    logic a_reg, a_next;
    logic b_reg, b_next;

    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        if (ctrl.shl_a)
        begin
            a_next = a_dn;
        end
        else
        begin
            case (ctrl.op)
                OP_LOAD:
                begin
                    a_next = load_a;
                    b_next = load_b;
                end
                OP_SH_BOTH:
                begin
                    a_next = a_up;
                    b_next = b_up;
                end
                OP_SH_A:     a_next = a_up;
                OP_SH_B:     b_next = b_up;
                OP_RED:      b_next = a_up ^ b_up;
                OP_RED_SWAP:
                begin
                    a_next = b_reg;
                    b_next = a_up ^ b_up;
                end
                OP_SWAP:
                begin
                    a_next = b_reg;
                    b_next = a_reg;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign a_bit = a_reg;
    assign b_bit = b_reg;
endmodule
`default_nettype wire

[src/gf2_poly_gcd_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel  dir  payload           transaction
// req      in   poly_a, poly_b    valid & ready
// rsp      out  gcd_poly          valid & ready
//
// binary euclid on a row of WIDTH bit cells, one shift or shift-xor step per cycle
// with either input zero the controller goes straight from the check state to the finish state;
// else the step loop of the controller walks down the two degree bounds
// one item at a time; the result register lets the next item in while it waits
// a result still waiting holds the controller in its last state
// reset clears control only; the cell contents need none
module gf2_poly_gcd_core
    import gpg_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    gpg_req_if.sink   req,
    gpg_rsp_if.source rsp
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_STRIP = 3'd2;
    localparam logic [2:0] S_ODD   = 3'd3;
    localparam logic [2:0] S_LOOP  = 3'd4;
    localparam logic [2:0] S_UNSH  = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] da_reg, da_next, db_reg, db_next, k_reg, k_next;
    logic             ov_reg, ov_next;
    logic [FIELD_W-1:0] res_reg, res_next;
    cell_ctrl_t       ctrl;
    logic [WIDTH-1:0] a_vec, b_vec;

    logic a_zero, b_zero;
    assign a_zero = ~|a_vec;
    assign b_zero = ~|b_vec;

    genvar i;
    generate
        for (i = 0; i < WIDTH; i++)
        begin : g_cell
            logic a_up, b_up, a_dn;
            if (i == WIDTH - 1)
            begin : g_top
                assign a_up = 1'b0;
                assign b_up = 1'b0;
            end
            else
            begin : g_mid
                assign a_up = a_vec[i+1];
                assign b_up = b_vec[i+1];
            end
            if (i == 0)
            begin : g_bot
                assign a_dn = 1'b0;
            end
            else
            begin : g_lo
                assign a_dn = a_vec[i-1];
            end
            gpg_cell u_cell (
                .clk    (clk),
                .ctrl   (ctrl),
                .load_a (req.poly_a[i]),
                .load_b (req.poly_b[i]),
                .a_up   (a_up),
                .b_up   (b_up),
                .a_dn   (a_dn),
                .a_bit  (a_vec[i]),
                .b_bit  (b_vec[i])
            );
        end
    endgenerate

    assign req.ready    = (state_reg == S_IDLE);
    assign rsp.valid    = ov_reg;
    assign rsp.gcd_poly = res_reg;

    always_comb
    begin
        state_next = state_reg;
        da_next    = da_reg;
        db_next    = db_reg;
        k_next     = k_reg;
        ov_next    = ov_reg;
        res_next   = res_reg;
        ctrl.op    = OP_HOLD;
        ctrl.shl_a = 1'b0;
        if (ov_reg && rsp.ready)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    ctrl.op    = OP_LOAD;
                    da_next    = CNT_W'(WIDTH - 1);
                    db_next    = CNT_W'(WIDTH - 1);
                    k_next     = '0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (a_zero)
                begin
                    ctrl.op    = OP_SWAP;
                    state_next = S_FIN;
                end
                else if (b_zero)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_STRIP;
                end
            end
            S_STRIP:
            begin
                if (!a_vec[0] && !b_vec[0])
                begin
                    ctrl.op = OP_SH_BOTH;
                    k_next  = k_reg + 1'b1;
                    da_next = da_reg - 1'b1;
                    db_next = db_reg - 1'b1;
                end
                else
                begin
                    state_next = S_ODD;
                end
            end
            S_ODD:
            begin
                if (!a_vec[0])
                begin
                    ctrl.op = OP_SH_A;
                    da_next = da_reg - 1'b1;
                end
                else
                begin
                    state_next = S_LOOP;
                end
            end
            S_LOOP:
            begin
                if (b_zero)
                begin
                    state_next = S_UNSH;
                end
                else if (!b_vec[0])
                begin
                    ctrl.op = OP_SH_B;
                    db_next = db_reg - 1'b1;
                end
                else if (db_reg < da_reg)
                begin
                    // bounds swap with the polynomials
                    ctrl.op = OP_RED_SWAP;
                    da_next = db_reg;
                    db_next = da_reg - 1'b1;
                end
                else
                begin
                    ctrl.op = OP_RED;
                    db_next = db_reg - 1'b1;
                end
            end
            S_UNSH:
            begin
                if (k_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    ctrl.shl_a = 1'b1;
                    k_next     = k_reg - 1'b1;
                end
            end
            S_FIN:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    ov_next    = 1'b1;
                    res_next   = FIELD_W'(a_vec);
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        da_reg  <= da_next;
        db_reg  <= db_next;
        k_reg   <= k_next;
        res_reg <= res_next;
    end
endmodule
`default_nettype wire

[src/gpg_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module gpg_checker
    import gpg_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               req_valid,
    input wire logic               req_ready,
    input wire logic               rsp_valid,
    input wire logic               rsp_ready,
    input wire logic [FIELD_W-1:0] gcd_poly
);
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(gcd_poly))
        else $error("result dropped or changed while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second transaction taken while busy");

    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !$rose(rsp_valid))
        else $error("result appeared one cycle after accept");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !req_ready || $past(!req_ready))
        else $error("result without a transaction in flight");
endmodule

bind gf2_poly_gcd_core gpg_checker u_gpg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .gcd_poly  (rsp.gcd_poly)
);
`default_nettype wire
